// ===== sv/led_strip_frame_buffer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// LED strip frame buffer assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ---------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_BUFFER_UNIT_ASSERT_SVH
`define LED_STRIP_FRAME_BUFFER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSFB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lsfb_pkg.sv =====
// ---------------------------------------------------------------------------
// LED strip frame buffer package
// Types and constants shared by the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package lsfb_pkg;

   localparam int IDX_W      = 16;
   localparam int COLOR_W    = 24;
   localparam int LEN_W      = 6;
   localparam int BRIGHT_W   = 5;
   localparam int WORD_W     = 32;
   localparam int REQ_DATA_W = 40;
   localparam int CSR_DATA_W = 6;

   localparam logic [2:0]        PIXEL_TAG      = 3'b111;
   localparam logic [LEN_W-1:0]  STRIP_LEN_RST  = 6'd62;
   localparam logic [BRIGHT_W-1:0] BRIGHT_RST   = 5'd31;
   localparam logic [WORD_W-1:0] START_WORD     = 32'h0000_0000;
   localparam logic [WORD_W-1:0] END_WORD       = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_SET   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_SHOW  = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_STRIP_LENGTH = 1'b0,
      CSR_BRIGHTNESS   = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE       = 2'd0,
      ST_GET        = 2'd1,
      ST_SHOW_START = 2'd2,
      ST_SHOW_BODY  = 2'd3
   } state_type;

   typedef enum logic [1:0] {
      PTR_HOLD = 2'd0,
      PTR_LOAD = 2'd1,
      PTR_ZERO = 2'd2,
      PTR_INC  = 2'd3
   } ptr_op_type;

   typedef enum logic [1:0] {
      SEL_GET   = 2'd0,
      SEL_START = 2'd1,
      SEL_PIXEL = 2'd2,
      SEL_END   = 2'd3
   } word_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      ptr_op_type   ptr_op;
      logic         wr_en;
      logic         clr_en;
      logic         emit;
      word_sel_type sel;
      logic         last;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_in_range;
      logic ptr_at_len;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/led_strip_frame_buffer_unit.sv =====
// Usage: commands arrive on the req_ stream, one beat per command, with the
// command code in req_tuser. Replies leave on the rsp_ stream; rsp_tuser is
// high for frame words and rsp_tlast marks the final beat of a command.
// Strip length and global brightness are written over the csr_ channel,
// which is always ready; the user must write them only while no command is
// in flight, which the block itself does not enforce. Set and clear
// produce no beat. Get enters the get state, which waits until the output
// register is free, loads the reply into it and returns to idle, where the
// next command is taken. Show emits the start word, one word per pixel in
// use and the end word, one beat per cycle from the output register while
// rsp_tready keeps it free. Clear resets every per-entry valid flag.
// Reset sets the strip length to 62, brightness to 31 and makes every pixel
// read as zero. When rsp_tready is low the output register holds its beat
// and the controller waits; req_tready stays low until the command is done.
// ---------------------------------------------------------------------------
// LED strip frame buffer unit
// Pixel store with set, get, clear and show commands for a chained LED strip.
// ---------------------------------------------------------------------------
`default_nettype none

module led_strip_frame_buffer_unit #(
   parameter int MAX_PIXELS = 62
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: pixel_index [15:0], pixel_color [39:16]
   input  wire logic [lsfb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: cmd [1:0]
   input  wire logic [1:0]                          req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: word [31:0]
   output logic [lsfb_pkg::WORD_W-1:0]              rsp_tdata,
   // tuser: is_frame [0]
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_index,
   input  wire logic [lsfb_pkg::CSR_DATA_W-1:0]     csr_data
);

   lsfb_pkg::ctl_type ctl;
   lsfb_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   lsfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .ctl        (ctl)
   );

   lsfb_dp #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .ctl        (ctl),
      .sts        (sts)
   );

endmodule

`default_nettype wire

// ===== sv/lsfb_ctrl.sv =====
// ---------------------------------------------------------------------------
// LED strip frame buffer controller
// Sequences set, get, clear and show commands and drives the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [1:0]        req_tuser,
   input  wire lsfb_pkg::sts_type sts,
   output lsfb_pkg::ctl_type      ctl
);

   lsfb_pkg::state_type state_ff, state_in;
   lsfb_pkg::cmd_type   cmd;

   assign cmd = lsfb_pkg::cmd_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsfb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ctl        = '{ptr_op: lsfb_pkg::PTR_HOLD, wr_en: 1'b0, clr_en: 1'b0,
                     emit: 1'b0, sel: lsfb_pkg::SEL_GET, last: 1'b0};
      unique case (state_ff)
         lsfb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (cmd)
                  lsfb_pkg::CMD_SET: begin
                     ctl.wr_en = sts.idx_in_range;
                  end
                  lsfb_pkg::CMD_GET: begin
                     ctl.ptr_op = lsfb_pkg::PTR_LOAD;
                     state_in   = lsfb_pkg::ST_GET;
                  end
                  lsfb_pkg::CMD_CLEAR: begin
                     ctl.clr_en = 1'b1;
                  end
                  lsfb_pkg::CMD_SHOW: begin
                     ctl.ptr_op = lsfb_pkg::PTR_ZERO;
                     state_in   = lsfb_pkg::ST_SHOW_START;
                  end
               endcase
            end
         end
         lsfb_pkg::ST_GET: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               ctl.sel  = lsfb_pkg::SEL_GET;
               ctl.last = 1'b1;
               state_in = lsfb_pkg::ST_IDLE;
            end
         end
         lsfb_pkg::ST_SHOW_START: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               ctl.sel  = lsfb_pkg::SEL_START;
               state_in = lsfb_pkg::ST_SHOW_BODY;
            end
         end
         lsfb_pkg::ST_SHOW_BODY: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               if (sts.ptr_at_len) begin
                  ctl.sel  = lsfb_pkg::SEL_END;
                  ctl.last = 1'b1;
                  state_in = lsfb_pkg::ST_IDLE;
               end else begin
                  ctl.sel    = lsfb_pkg::SEL_PIXEL;
                  ctl.ptr_op = lsfb_pkg::PTR_INC;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/lsfb_dp.sv =====
// ---------------------------------------------------------------------------
// LED strip frame buffer datapath
// Pixel store, settings registers, read pointer and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfb_dp #(
   parameter int MAX_PIXELS = 62
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [lsfb_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_index,
   input  wire logic [lsfb_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lsfb_pkg::WORD_W-1:0]              rsp_tdata,
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   input  wire lsfb_pkg::ctl_type                   ctl,
   output lsfb_pkg::sts_type                        sts
);

   localparam int AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam logic [lsfb_pkg::LEN_W-1:0] MaxLen = lsfb_pkg::LEN_W'(MAX_PIXELS);

   logic [lsfb_pkg::IDX_W-1:0]    pixel_index;
   logic [lsfb_pkg::COLOR_W-1:0]  pixel_color;
   logic [lsfb_pkg::LEN_W-1:0]    strip_len_ff;
   logic [lsfb_pkg::BRIGHT_W-1:0] bright_ff;
   logic [lsfb_pkg::LEN_W-1:0]    used_len;
   logic [lsfb_pkg::LEN_W-1:0]    ptr_ff, ptr_in;
   logic                          rd_ok;
   logic [AddrW-1:0]              rd_addr;
   logic [AddrW-1:0]              wr_addr;
   logic [lsfb_pkg::COLOR_W-1:0]  pix_mem_ff [MAX_PIXELS];
   logic [MAX_PIXELS-1:0]         vld_ff;
   logic [lsfb_pkg::COLOR_W-1:0]  rdata_ff;
   logic                          rvld_ff;
   logic                          get_ok_ff;
   logic [lsfb_pkg::COLOR_W-1:0]  rd_color;
   logic [lsfb_pkg::WORD_W-1:0]   word;
   logic                          out_valid_ff;
   logic [lsfb_pkg::WORD_W-1:0]   out_word_ff;
   logic                          out_frame_ff;
   logic                          out_last_ff;

   assign pixel_index = req_tdata[lsfb_pkg::IDX_W-1:0];
   assign pixel_color = req_tdata[lsfb_pkg::IDX_W +: lsfb_pkg::COLOR_W];

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_len_ff <= lsfb_pkg::STRIP_LEN_RST;
         bright_ff    <= lsfb_pkg::BRIGHT_RST;
      end else if (csr_valid) begin
         unique case (lsfb_pkg::csr_reg_type'(csr_index))
            lsfb_pkg::CSR_STRIP_LENGTH: strip_len_ff <= csr_data;
            lsfb_pkg::CSR_BRIGHTNESS:   bright_ff    <= csr_data[lsfb_pkg::BRIGHT_W-1:0];
         endcase
      end
   end

   // A length above the store size acts as the store size.
   assign used_len = (strip_len_ff > MaxLen) ? MaxLen : strip_len_ff;

   assign sts.idx_in_range = pixel_index < lsfb_pkg::IDX_W'(used_len);
   assign sts.ptr_at_len   = ptr_ff == used_len;
   assign sts.out_free     = !out_valid_ff || rsp_tready;

   always_comb begin
      unique case (ctl.ptr_op)
         lsfb_pkg::PTR_HOLD: ptr_in = ptr_ff;
         lsfb_pkg::PTR_LOAD: ptr_in = pixel_index[lsfb_pkg::LEN_W-1:0];
         lsfb_pkg::PTR_ZERO: ptr_in = '0;
         lsfb_pkg::PTR_INC:  ptr_in = ptr_ff + 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (ctl.ptr_op == lsfb_pkg::PTR_LOAD) begin
         get_ok_ff <= sts.idx_in_range;
      end
   end

   // The read is addressed by the next pointer value, so the registered
   // read data always belongs to the current pointer.
   assign rd_ok   = ptr_in < lsfb_pkg::LEN_W'(MAX_PIXELS);
   assign rd_addr = ptr_in[AddrW-1:0];
   assign wr_addr = pixel_index[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         pix_mem_ff[wr_addr] <= pixel_color;
      end
      if (rd_ok) begin
         rdata_ff <= pix_mem_ff[rd_addr];
      end
      rvld_ff <= rd_ok ? vld_ff[rd_addr] : 1'b0;
   end

   // An entry without its valid flag reads as zero.
   always_ff @(posedge clock) begin
      if (reset || ctl.clr_en) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_color = rvld_ff ? rdata_ff : '0;

   always_comb begin
      unique case (ctl.sel)
         lsfb_pkg::SEL_GET:
            word = get_ok_ff ? {8'h00, rd_color} : '0;
         lsfb_pkg::SEL_START:
            word = lsfb_pkg::START_WORD;
         lsfb_pkg::SEL_PIXEL:
            word = {lsfb_pkg::PIXEL_TAG, bright_ff, rd_color[7:0], rd_color[15:8],
                    rd_color[23:16]};
         lsfb_pkg::SEL_END:
            word = lsfb_pkg::END_WORD;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         out_word_ff  <= word;
         out_frame_ff <= ctl.sel != lsfb_pkg::SEL_GET;
         out_last_ff  <= ctl.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = out_frame_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== sv/lsfb_checker.sv =====
// ---------------------------------------------------------------------------
// LED strip frame buffer port checker
// Checks the reply stream and the command handshake over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "led_strip_frame_buffer_unit_assert.svh"

module lsfb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic [lsfb_pkg::WORD_W-1:0]       rsp_tdata,
   input wire logic                              rsp_tuser,
   input wire logic                              rsp_tlast,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready
);

   // A stalled beat keeps its contents.
   `LSFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "reply beat changed under stall")

   // A read reply is always the only beat of its command.
   `LSFB_ASSERT_SAME(a_get_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast, "read reply not marked last")

   // While a frame is still being sent no new command is taken.
   `LSFB_ASSERT_SAME(a_busy, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready, "command taken during a frame")

   // The all-zero start word never ends a frame.
   `LSFB_ASSERT_SAME(a_start, clock, reset, rsp_tvalid && rsp_tuser && (rsp_tdata == 32'h0), !rsp_tlast, "start word marked last")

endmodule

bind led_strip_frame_buffer_unit lsfb_checker u_lsfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
